>>> hw/rtl/kmm_pkg.sv
// ----------------------------------------------------------------------------
// kmm_pkg: shared types and constants of the k-mismatch pattern matcher
// Holds the item types of both channels, the register indexes and the
// sizes of the comparator chain and the text counters.
// ----------------------------------------------------------------------------
package kmm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int IDX_W       = $clog2(PATTERN_MAX);
	localparam int LEN_W       = 6;
	localparam int CNT_W       = 21;
	localparam int START_W     = 20;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CNT_W-1:0] TEXT_MAX = CNT_W'(1048576);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_MISMATCHES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3  = 3'd5;

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef logic [PATTERN_MAX-1:0][7:0] pattern_bytes_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       text_end;
	} text_item_t;

	typedef struct packed {
		logic               result_kind;
		logic [START_W-1:0] start_position;
		logic [LEN_W-1:0]   mismatch_count;
		logic [CNT_W-1:0]   match_total;
		logic               last_result;
	} result_item_t;

	typedef struct packed {
		logic               text_end;
		logic               evaluate;
		logic [START_W-1:0] start;
	} stage_ctl_t;

endpackage

>>> hw/rtl/kmm_cell.sv
// ----------------------------------------------------------------------------
// kmm_cell: one window cell of the comparator chain
// Holds one text byte, hands it to the next cell on every accepted item and
// compares it with the pattern byte that lines up with it for the current
// pattern length.
// ----------------------------------------------------------------------------
module kmm_cell (
	input  logic                    clk,
	input  logic                    shift_en,
	input  logic [7:0]              din,
	output logic [7:0]              dout,
	input  logic                    capture_en,
	input  kmm_pkg::pattern_bytes_t pattern,
	input  logic [kmm_pkg::LEN_W-1:0] len_eff,
	input  logic [kmm_pkg::IDX_W-1:0] cell_idx,
	output logic                    diff_s2
);
	import kmm_pkg::*;

	logic [7:0]       byte_q;
	logic [LEN_W-1:0] pat_sel;
	logic             in_use;
	logic [7:0]       pat_byte;

	assign in_use   = LEN_W'(cell_idx) < len_eff;
	assign pat_sel  = len_eff - LEN_W'(1) - LEN_W'(cell_idx);
	assign pat_byte = pattern[pat_sel[IDX_W-1:0]];
	assign dout     = byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= din;
		end
		if (capture_en) begin
			diff_s2 <= in_use && (byte_q != pat_byte);
		end
	end

endmodule

>>> hw/rtl/kmm_tally.sv
// ----------------------------------------------------------------------------
// kmm_tally: mismatch count, match decision and result queue
// Counts the differing cells of a window, decides on a match, keeps the
// match total of the text and queues up to two result items.
// ----------------------------------------------------------------------------
module kmm_tally (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s1_valid,
	input  kmm_pkg::stage_ctl_t          s1_ctl,
	output logic                         s2_load,
	input  logic [kmm_pkg::PATTERN_MAX-1:0] diff_s2,
	input  logic [kmm_pkg::LEN_W-1:0]    max_mismatches,
	output logic                         result_valid,
	input  logic                         result_stall,
	output kmm_pkg::result_item_t        result_item
);
	import kmm_pkg::*;

	logic             s2_valid_q;
	stage_ctl_t       ctl_s2;
	logic [CNT_W-1:0] matches_q;
	logic [1:0]       fill_q;
	result_item_t     slot0_q;
	result_item_t     slot1_q;

	logic [LEN_W-1:0] mism;
	logic             is_match;
	logic             pop;
	logic             drain;
	logic [CNT_W-1:0] matches_new;
	result_item_t     match_res;
	result_item_t     end_res;
	logic [1:0]       fill_next;
	result_item_t     slot0_next;
	result_item_t     slot1_next;

	assign mism     = LEN_W'($countones(diff_s2));
	assign is_match = ctl_s2.evaluate && (mism <= max_mismatches);
	assign pop      = result_valid && !result_stall;
	assign drain    = s2_valid_q && ((fill_q == 2'd0) || (fill_q == 2'd1 && pop));
	assign s2_load  = s1_valid && (!s2_valid_q || drain);

	assign matches_new = (is_match && matches_q < TEXT_MAX) ? matches_q + CNT_W'(1) : matches_q;

	always_comb begin
		match_res.result_kind    = KIND_MATCH;
		match_res.start_position = ctl_s2.start;
		match_res.mismatch_count = mism;
		match_res.match_total    = matches_new;
		match_res.last_result    = !ctl_s2.text_end;
		end_res.result_kind      = KIND_END;
		end_res.start_position   = '0;
		end_res.mismatch_count   = '0;
		end_res.match_total      = matches_new;
		end_res.last_result      = 1'b1;
	end

	always_comb begin
		fill_next  = fill_q;
		slot0_next = slot0_q;
		slot1_next = slot1_q;
		if (pop) begin
			slot0_next = slot1_q;
			fill_next  = fill_q - 2'd1;
		end
		if (drain) begin
			if (is_match && ctl_s2.text_end) begin
				slot0_next = match_res;
				slot1_next = end_res;
				fill_next  = 2'd2;
			end else if (is_match) begin
				slot0_next = match_res;
				fill_next  = 2'd1;
			end else if (ctl_s2.text_end) begin
				slot0_next = end_res;
				fill_next  = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			matches_q  <= '0;
			fill_q     <= 2'd0;
		end else begin
			if (s2_load) begin
				s2_valid_q <= 1'b1;
			end else if (drain) begin
				s2_valid_q <= 1'b0;
			end
			if (drain) begin
				matches_q <= ctl_s2.text_end ? '0 : matches_new;
			end
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			ctl_s2 <= s1_ctl;
		end
		slot0_q <= slot0_next;
		slot1_q <= slot1_next;
	end

	assign result_valid = fill_q != 2'd0;
	assign result_item  = slot0_q;

endmodule

>>> hw/rtl/k_mismatch_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// k_mismatch_pattern_matcher_top: k-mismatch string matcher
// Compares the newest text window with a pattern of up to 32 bytes.
// ----------------------------------------------------------------------------
// Text bytes enter on the text channel, one item per byte, with text_end on
// the final byte of a text. The result channel returns a match item for
// every window that differs from the pattern in at most max_mismatches
// places, and an end-of-text item carrying the match total after the final
// byte. Registers are written on the cfg channel, which is always ready.
// The user must write them only while no item is in flight; the block
// itself does not enforce it. Each accepted byte shifts the row of 32
// window cells. When the window stage moves on, every cell registers
// whether its byte differs from its pattern byte; when the count stage
// drains, the differing cells are counted and the results are queued.
// The chain takes one byte per cycle while result_stall is low and each
// byte yields at most one result; a byte that yields two results holds
// the chain back at the two-entry result queue.
// Reset empties the pipeline and the queue and clears the position, the
// match total and the registers, but sets the pattern length to 1.
// With result_stall held, the queue fills and text_stall rises; no item drops.
// ----------------------------------------------------------------------------
module k_mismatch_pattern_matcher_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           text_valid,
	output logic                           text_stall,
	input  kmm_pkg::text_item_t            text_item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output kmm_pkg::result_item_t          result_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [kmm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kmm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kmm_pkg::*;

	logic [LEN_W-1:0]      max_mism_q;
	logic [LEN_W-1:0]      plen_q;
	logic [CFG_DATA_W-1:0] pat_word_q [4];
	logic [CNT_W-1:0]      pos_q;
	logic                  s1_valid_q;
	stage_ctl_t            ctl_s1;

	logic                  accept;
	logic                  s2_load;
	logic [LEN_W-1:0]      len_eff;
	pattern_bytes_t        pattern;
	logic                  counted;
	logic [CNT_W-1:0]      pos_new;
	logic [7:0]            win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] diff_s2;

	assign cfg_ready  = 1'b1;
	assign text_stall = s1_valid_q && !s2_load;
	assign accept     = text_valid && !text_stall;

	always_comb begin
		if (plen_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (plen_q > LEN_W'(PATTERN_MAX)) begin
			len_eff = LEN_W'(PATTERN_MAX);
		end else begin
			len_eff = plen_q;
		end
	end

	assign pattern = {pat_word_q[3], pat_word_q[2], pat_word_q[1], pat_word_q[0]};
	assign counted = pos_q < TEXT_MAX;
	assign pos_new = counted ? pos_q + CNT_W'(1) : pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mism_q <= '0;
			plen_q     <= LEN_W'(1);
			for (int i = 0; i < 4; i++) begin
				pat_word_q[i] <= '0;
			end
			pos_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MAX_MISMATCHES: max_mism_q <= cfg_data[LEN_W-1:0];
					REG_PATTERN_LENGTH: plen_q <= cfg_data[LEN_W-1:0];
					REG_PATTERN_WORD0:  pat_word_q[0] <= cfg_data;
					REG_PATTERN_WORD1:  pat_word_q[1] <= cfg_data;
					REG_PATTERN_WORD2:  pat_word_q[2] <= cfg_data;
					REG_PATTERN_WORD3:  pat_word_q[3] <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				pos_q      <= text_item.text_end ? '0 : pos_new;
				s1_valid_q <= 1'b1;
			end else if (s2_load) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.text_end <= text_item.text_end;
			ctl_s1.evaluate <= counted && (pos_new >= CNT_W'(len_eff));
			ctl_s1.start    <= START_W'(pos_new - CNT_W'(len_eff));
		end
	end

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		logic [7:0] din;
		if (i == 0) begin : g_head
			assign din = text_item.text_char;
		end else begin : g_link
			assign din = win[i-1];
		end
		kmm_cell u_cell (
			.clk        (clk),
			.shift_en   (accept),
			.din        (din),
			.dout       (win[i]),
			.capture_en (s2_load),
			.pattern    (pattern),
			.len_eff    (len_eff),
			.cell_idx   (IDX_W'(i)),
			.diff_s2    (diff_s2[i])
		);
	end

	kmm_tally u_tally (
		.clk            (clk),
		.arst_n         (arst_n),
		.s1_valid       (s1_valid_q),
		.s1_ctl         (ctl_s1),
		.s2_load        (s2_load),
		.diff_s2        (diff_s2),
		.max_mismatches (max_mism_q),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_item    (result_item)
	);

`ifndef ASSERT_OFF
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= TEXT_MAX)
		else $error("text position ran past its limit");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.result_kind == KIND_END |->
		result_item.start_position == '0 && result_item.mismatch_count == '0 &&
		result_item.last_result)
		else $error("end-of-text item carries stray fields");

	a_mism_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.result_kind == KIND_MATCH |->
		result_item.mismatch_count <= LEN_W'(PATTERN_MAX))
		else $error("mismatch count exceeds the window size");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s2_load |=> s1_valid_q && $stable(ctl_s1))
		else $error("stalled window stage lost its item");
`endif

endmodule

>>> bench/tb_k_mismatch_pattern_matcher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_k_mismatch_pattern_matcher_top: self-checking bench of the k-mismatch matcher
// Streams text bytes into the matcher under several pattern, length and
// mismatch-limit settings and scores every window in a local copy of the
// matcher. Each match and end-of-text item that comes back is compared
// field by field with the oldest outstanding report. The text side idles
// and the result side stalls at random, and the result side also holds off
// long enough to fill the matcher.
// ----------------------------------------------------------------------------
module tb_k_mismatch_pattern_matcher_top;

	import kmm_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_GAP      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  text_valid;
	logic                  text_stall;
	text_item_t            text_item;
	logic                  result_valid;
	logic                  result_stall;
	result_item_t          result_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Local copy of the matcher's registers and text state.
	logic [5:0]       limit_mismatches;
	logic [5:0]       length_reg;
	logic [255:0]     pattern_bits;
	logic [7:0]       window_q [PATTERN_MAX];
	logic [CNT_W-1:0] text_pos;
	logic [CNT_W-1:0] text_matches;

	result_item_t reports_due[$];

	int  error_count;
	int  bytes_sent;
	int  reports_checked;
	int  matches_checked;
	int  settings_used;
	int  cycle_count;
	int  hold_cycles;
	bit  send_idle;
	bit  recv_idle;

	k_mismatch_pattern_matcher_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_item    (text_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d reports outstanding.",
				cycle_count, reports_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_error(input string what);
		error_count++;
		$display("ERROR at %0t: %s", $realtime, what);
	endtask

	task automatic queue_report(input result_item_t rep);
		reports_due = {reports_due, rep};
	endtask

	function automatic int active_length();
		if (length_reg == 0)
			return 1;
		if (length_reg > PATTERN_MAX)
			return PATTERN_MAX;
		return int'(length_reg);
	endfunction

	task automatic clear_text_state();
		for (int i = 0; i < PATTERN_MAX; i++)
			window_q[i] = 8'h00;
		text_pos = '0;
		text_matches = '0;
	endtask

	// Shifts one byte into the window and queues the reports it causes.
	task automatic scan_text_byte(input text_item_t item);
		result_item_t rep;
		int len;
		int mism;
		bit counted;
		len = active_length();
		for (int i = PATTERN_MAX - 1; i > 0; i--)
			window_q[i] = window_q[i - 1];
		window_q[0] = item.text_char;
		counted = 1'b0;
		if (text_pos < TEXT_MAX) begin
			text_pos++;
			counted = 1'b1;
		end
		if (counted && text_pos >= len) begin
			mism = 0;
			for (int i = 0; i < len; i++)
				if (window_q[len - 1 - i] != pattern_bits[i * 8 +: 8])
					mism++;
			if (mism <= limit_mismatches) begin
				if (text_matches < TEXT_MAX)
					text_matches++;
				rep.result_kind    = KIND_MATCH;
				rep.start_position = START_W'(text_pos - CNT_W'(len));
				rep.mismatch_count = LEN_W'(mism);
				rep.match_total    = text_matches;
				rep.last_result    = !item.text_end;
				queue_report(rep);
			end
		end
		if (item.text_end) begin
			rep.result_kind    = KIND_END;
			rep.start_position = '0;
			rep.mismatch_count = '0;
			rep.match_total    = text_matches;
			rep.last_result    = 1'b1;
			queue_report(rep);
			clear_text_state();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_MISMATCHES: limit_mismatches = data[5:0];
			REG_PATTERN_LENGTH: length_reg = data[5:0];
			REG_PATTERN_WORD0: pattern_bits[0 +: 64] = data;
			REG_PATTERN_WORD1: pattern_bits[64 +: 64] = data;
			REG_PATTERN_WORD2: pattern_bits[128 +: 64] = data;
			REG_PATTERN_WORD3: pattern_bits[192 +: 64] = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] c, input logic last);
		text_item_t item;
		int gap;
		item.text_char = c;
		item.text_end  = last;
		gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid <= 1'b1;
		text_item  <= item;
		@(posedge clk);
		while (text_stall) @(posedge clk);
		scan_text_byte(item);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		text_valid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mixes planted pattern copies with a few corrupted bytes, pattern
	// bytes in the wrong place and fully random bytes.
	task automatic send_text(input int n_bytes, input bit with_end);
		logic [7:0] text_q[$];
		int len;
		int pos;
		len = active_length();
		while (text_q.size() < n_bytes) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					pos = text_q.size();
					for (int i = 0; i < len; i++)
						text_q = {text_q, pattern_bits[i * 8 +: 8]};
					repeat ($urandom_range(0, 2))
						text_q[pos + $urandom_range(0, len - 1)] ^= 8'($urandom_range(1, 255));
				end
				2: begin
					text_q = {text_q, 8'($urandom)};
				end
				default: begin
					text_q = {text_q, pattern_bits[$urandom_range(0, len - 1) * 8 +: 8]};
				end
			endcase
		end
		for (int i = 0; i < n_bytes; i++)
			send_char(text_q[i], with_end && (i == n_bytes - 1));
	endtask

	task automatic load_setting(input logic [5:0] len, input logic [5:0] limit);
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
		write_reg(REG_MAX_MISMATCHES, CFG_DATA_W'(limit));
		write_reg(REG_PATTERN_WORD0, {$urandom, $urandom});
		write_reg(REG_PATTERN_WORD1, {$urandom, $urandom});
		write_reg(REG_PATTERN_WORD2, {$urandom, $urandom});
		write_reg(REG_PATTERN_WORD3, {$urandom, $urandom});
		settings_used++;
	endtask

	task automatic test_reset_values();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		wait_drained();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_PATTERN_LENGTH, '0);
		write_reg(REG_MAX_MISMATCHES, '1);
		write_reg(REG_SPARE_LOW, '1);
		write_reg(REG_SPARE_HIGH, '1);
		send_char(8'hFF, 1'b1);
		wait_drained();
		write_reg(REG_PATTERN_LENGTH, '1);
		write_reg(REG_MAX_MISMATCHES, '0);
		write_reg(REG_PATTERN_WORD0, '1);
		write_reg(REG_PATTERN_WORD1, '1);
		write_reg(REG_PATTERN_WORD2, '1);
		write_reg(REG_PATTERN_WORD3, '1);
		send_char(8'hFF, 1'b0);
		send_char(8'hFF, 1'b1);
		wait_drained();
		settings_used += 2;
	endtask

	task automatic test_mismatch_limit();
		logic [7:0] b;
		load_setting(6'd4, 6'd1);
		for (int copy = 0; copy < 3; copy++)
			for (int i = 0; i < 4; i++) begin
				b = pattern_bits[i * 8 +: 8];
				if (copy > 0 && i == 1)
					b = ~b;
				if (copy > 1 && i == 3)
					b = b ^ 8'h80;
				send_char(b, copy == 2 && i == 3);
			end
		wait_drained();
	endtask

	task automatic test_random_texts(input int n_bytes);
		int first;
		int phase_start;
		int len;
		int limit;
		first = bytes_sent;
		while (bytes_sent - first < n_bytes) begin
			case ($urandom_range(0, 9))
				0: begin
					len = PATTERN_MAX;
					limit = 0;
				end
				1: begin
					len = PATTERN_MAX;
					limit = PATTERN_MAX;
				end
				2: begin
					len = 1;
					limit = 0;
				end
				3: begin
					len = $urandom_range(1, PATTERN_MAX);
					limit = $urandom_range(0, 63);
				end
				default: begin
					len = $urandom_range(1, 8);
					limit = $urandom_range(0, (len < 3) ? len : 3);
				end
			endcase
			load_setting(6'(len), 6'(limit));
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < 100)
				send_text($urandom_range(1, 3 * len + 8), 1'b1);
			wait_drained();
		end
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// Every byte matches, so the held-off result side backs up into the text side.
	task automatic test_result_backpressure();
		load_setting(6'd1, 6'd63);
		send_idle = 1'b0;
		hold_cycles = 300;
		for (int i = 0; i < 60; i++)
			send_char(8'($urandom), i == 59);
		wait_drained();
		send_idle = 1'b1;
	endtask

	task automatic test_sender_pause();
		load_setting(6'd3, 6'd1);
		send_text(20, 1'b0);
		wait_drained();
		send_text(20, 1'b1);
		wait_drained();
	endtask

	always @(posedge clk) begin : check_results
		result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (reports_due.size() == 0) begin
				report_error("result arrived with no report outstanding");
			end else begin
				want = reports_due.pop_front();
				reports_checked++;
				if (want.result_kind == KIND_MATCH)
					matches_checked++;
				if (result_item.result_kind != want.result_kind)
					report_error($sformatf("result_kind %0d, expected %0d",
						result_item.result_kind, want.result_kind));
				if (result_item.start_position != want.start_position)
					report_error($sformatf("start_position %0d, expected %0d",
						result_item.start_position, want.start_position));
				if (result_item.mismatch_count != want.mismatch_count)
					report_error($sformatf("mismatch_count %0d, expected %0d",
						result_item.mismatch_count, want.mismatch_count));
				if (result_item.match_total != want.match_total)
					report_error($sformatf("match_total %0d, expected %0d",
						result_item.match_total, want.match_total));
				if (result_item.last_result != want.last_result)
					report_error($sformatf("last_result %0d, expected %0d",
						result_item.last_result, want.last_result));
			end
		end
	end

	initial begin : result_receiver
		int wait_cycles;
		result_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			wait_cycles = hold_cycles + (recv_idle ? $urandom_range(0, MAX_GAP) : 0);
			hold_cycles = 0;
			if (wait_cycles > 0) begin
				result_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	initial begin
		text_valid <= 1'b0;
		text_item  <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		arst_n     <= 1'b0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		limit_mismatches = '0;
		length_reg = 6'd1;
		pattern_bits = '0;
		clear_text_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_register_extremes();
		test_mismatch_limit();
		test_random_texts(1050);
		test_result_backpressure();
		test_sender_pause();
		wait_drained();
		$display("Sent %0d text bytes over %0d register settings.", bytes_sent, settings_used);
		$display("Checked %0d results, %0d of them matches.", reports_checked, matches_checked);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> k_mismatch_pattern_matcher_top.f
hw/rtl/kmm_pkg.sv
hw/rtl/kmm_cell.sv
hw/rtl/kmm_tally.sv
hw/rtl/k_mismatch_pattern_matcher_top.sv
bench/tb_k_mismatch_pattern_matcher_top.sv
